// ===== rtl/imhd_pkg.sv =====
// ----------------------------------------------------------------------------
// imhd_pkg
// Shared sizes, memory word layouts and request structs for the indexed
// min-heap with decrease-key.
// ----------------------------------------------------------------------------
package imhd_pkg;

	localparam int NODE_COUNT = 256;
	localparam int DIST_W     = 32;
	localparam int ID_W       = 8;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int HEAP_DEPTH = NODE_COUNT + 1;
	localparam int POS_W      = $clog2(HEAP_DEPTH);

	// request type codes
	localparam logic REQ_RELAX = 1'b0;
	localparam logic REQ_POP   = 1'b1;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [ID_W-1:0]   id_t;

	// per-node record: distance, predecessor, 1-based heap slot (0 = absent)
	typedef struct packed {
		dist_t distance;
		id_t   pred;
		pos_t  pos;
	} node_word_t;

	localparam int NODE_WORD_W = $bits(node_word_t);

	// node store access: write port and read address
	typedef struct packed {
		logic       we;
		node_t      waddr;
		node_word_t wdata;
		node_t      raddr;
	} node_req_t;

	// heap slot store access: write port and read address
	typedef struct packed {
		logic  we;
		pos_t  waddr;
		node_t wdata;
		pos_t  raddr;
	} heap_req_t;

endpackage

// ===== rtl/imhd_ram.sv =====
// ----------------------------------------------------------------------------
// imhd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imhd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port (read returns old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/imhd_ctrl.sv =====
// ----------------------------------------------------------------------------
// imhd_ctrl
// Sequencer for relax and pop transactions: reads, compares and writes back
// node records and heap slots level by level, keeps the reached
// marks, the heap count and the result register.
// ----------------------------------------------------------------------------
module imhd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [7:0]            node_id,
	input  logic [7:0]            pred_id,
	input  logic [31:0]           offered_dist,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  relax_taken,
	output logic                  pop_valid,
	output logic [7:0]            popped_node,
	output logic [31:0]           popped_dist,
	output logic [7:0]            popped_pred,
	output imhd_pkg::node_req_t   node_req,
	input  imhd_pkg::node_word_t  node_rdata,
	output imhd_pkg::heap_req_t   heap_req,
	input  imhd_pkg::node_t       heap_rdata
);

	typedef enum logic [4:0] {
		S_IDLE, S_R_CHK, S_UP_LOOP, S_UP_NODE, S_UP_CMP, S_UP_FIN,
		S_POP_TOP, S_POP_LAST, S_POP_LASTN, S_DN_LOOP, S_DN_LEFT,
		S_DN_LNODE, S_DN_RNODE, S_DN_CMP, S_DN_FIN, S_POP_CLR, S_DONE
	} state_t;

	state_t               state_q;
	logic                 reached_q [imhd_pkg::NODE_COUNT];
	imhd_pkg::pos_t       hc_q, i_q, j_q;
	imhd_pkg::node_t      nd_q, top_q, last_q, ch_q, cr_q;
	imhd_pkg::dist_t      d_q, top_dist_q, ld_q, ch_dist_q;
	imhd_pkg::id_t        pred_q, top_pred_q, lpred_q, ch_pred_q;
	logic                 op_q, flag_q, node_ok_q;
	logic                 out_valid_q, relax_taken_q, pop_valid_q;
	logic [7:0]           popped_node_q, popped_pred_q;
	logic [31:0]          popped_dist_q;

	logic                 accept;
	logic                 nd_reached, taken, append, full, dn_go;
	imhd_pkg::pos_t       old_pos;

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign relax_taken = relax_taken_q;
	assign pop_valid   = pop_valid_q;
	assign popped_node = popped_node_q;
	assign popped_dist = popped_dist_q;
	assign popped_pred = popped_pred_q;

	// relax decision from the node record read for the offered node
	always_comb begin
		nd_reached = reached_q[nd_q];
		old_pos    = nd_reached ? node_rdata.pos : '0;
		taken      = node_ok_q && (!nd_reached || (d_q < node_rdata.distance));
		append     = (old_pos == '0) || (old_pos > hc_q);
		full       = (hc_q >= imhd_pkg::pos_t'(imhd_pkg::NODE_COUNT));
		dn_go      = (i_q < hc_q) && ({i_q, 1'b0} <= {1'b0, hc_q});
	end

	// memory addresses and write-backs per state
	always_comb begin
		node_req = '0;
		heap_req = '0;
		case (state_q)
			S_IDLE: begin
				node_req.raddr = imhd_pkg::node_t'(node_id);
				heap_req.raddr = imhd_pkg::pos_t'(1);
			end
			S_UP_LOOP: heap_req.raddr = i_q >> 1;
			S_UP_NODE: node_req.raddr = heap_rdata;
			S_UP_CMP: begin
				if (d_q < node_rdata.distance) begin
					node_req.we    = 1'b1;
					node_req.waddr = ch_q;
					node_req.wdata = '{distance: node_rdata.distance, pred: node_rdata.pred,
						pos: i_q};
					heap_req.we    = 1'b1;
					heap_req.waddr = i_q;
					heap_req.wdata = ch_q;
				end
			end
			S_UP_FIN: begin
				node_req.we    = 1'b1;
				node_req.waddr = nd_q;
				node_req.wdata = '{distance: d_q, pred: pred_q, pos: i_q};
				heap_req.we    = 1'b1;
				heap_req.waddr = i_q;
				heap_req.wdata = nd_q;
			end
			S_POP_TOP: begin
				heap_req.raddr = hc_q;
				node_req.raddr = heap_rdata;
			end
			S_POP_LAST: node_req.raddr = heap_rdata;
			S_DN_LOOP:  heap_req.raddr = imhd_pkg::pos_t'({i_q, 1'b0});
			S_DN_LEFT: begin
				node_req.raddr = heap_rdata;
				heap_req.raddr = (j_q < hc_q) ? imhd_pkg::pos_t'(j_q + 1'b1) : j_q;
			end
			S_DN_LNODE: node_req.raddr = heap_rdata;
			S_DN_CMP: begin
				if (ch_dist_q < ld_q) begin
					node_req.we    = 1'b1;
					node_req.waddr = ch_q;
					node_req.wdata = '{distance: ch_dist_q, pred: ch_pred_q, pos: i_q};
					heap_req.we    = 1'b1;
					heap_req.waddr = i_q;
					heap_req.wdata = ch_q;
				end
			end
			S_DN_FIN: begin
				node_req.we    = 1'b1;
				node_req.waddr = last_q;
				node_req.wdata = '{distance: ld_q, pred: lpred_q, pos: i_q};
				heap_req.we    = 1'b1;
				heap_req.waddr = i_q;
				heap_req.wdata = last_q;
			end
			S_POP_CLR: begin
				node_req.we    = 1'b1;
				node_req.waddr = top_q;
				node_req.wdata = '{distance: top_dist_q, pred: top_pred_q, pos: '0};
			end
			default: ;
		endcase
	end

	// sequencer, heap count, reached marks and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			hc_q          <= '0;
			out_valid_q   <= 1'b0;
			op_q          <= 1'b0;
			flag_q        <= 1'b0;
			relax_taken_q <= 1'b0;
			pop_valid_q   <= 1'b0;
			popped_node_q <= '0;
			popped_dist_q <= '0;
			popped_pred_q <= '0;
			for (int k = 0; k < imhd_pkg::NODE_COUNT; k++) begin
				reached_q[k] <= 1'b0;
			end
		end else begin
			// result taken; a result loaded in S_DONE keeps it valid instead
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= req_type;
						nd_q      <= imhd_pkg::node_t'(node_id);
						node_ok_q <= (32'(node_id) < imhd_pkg::NODE_COUNT);
						pred_q    <= imhd_pkg::id_t'(pred_id);
						d_q       <= imhd_pkg::dist_t'(offered_dist);
						if (req_type == imhd_pkg::REQ_RELAX) begin
							state_q <= S_R_CHK;
						end else if (hc_q == '0) begin
							flag_q  <= 1'b0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_POP_TOP;
						end
					end
				end
				S_R_CHK: begin
					if (taken && !(append && full)) begin
						reached_q[nd_q] <= 1'b1;
						flag_q          <= 1'b1;
						if (append) begin
							hc_q <= imhd_pkg::pos_t'(hc_q + 1'b1);
							i_q  <= imhd_pkg::pos_t'(hc_q + 1'b1);
						end else begin
							i_q <= old_pos;
						end
						state_q <= S_UP_LOOP;
					end else begin
						flag_q  <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_UP_LOOP: state_q <= (i_q <= imhd_pkg::pos_t'(1)) ? S_UP_FIN : S_UP_NODE;
				S_UP_NODE: begin
					ch_q    <= heap_rdata;
					state_q <= S_UP_CMP;
				end
				S_UP_CMP: begin
					if (d_q < node_rdata.distance) begin
						i_q     <= i_q >> 1;
						state_q <= S_UP_LOOP;
					end else begin
						state_q <= S_UP_FIN;
					end
				end
				S_UP_FIN: state_q <= S_DONE;
				S_POP_TOP: begin
					top_q   <= heap_rdata;
					state_q <= S_POP_LAST;
				end
				S_POP_LAST: begin
					top_dist_q <= node_rdata.distance;
					top_pred_q <= node_rdata.pred;
					last_q     <= heap_rdata;
					hc_q       <= imhd_pkg::pos_t'(hc_q - 1'b1);
					state_q    <= S_POP_LASTN;
				end
				S_POP_LASTN: begin
					ld_q    <= node_rdata.distance;
					lpred_q <= node_rdata.pred;
					i_q     <= imhd_pkg::pos_t'(1);
					state_q <= S_DN_LOOP;
				end
				S_DN_LOOP: begin
					j_q     <= imhd_pkg::pos_t'({i_q, 1'b0});
					state_q <= dn_go ? S_DN_LEFT : S_DN_FIN;
				end
				S_DN_LEFT: begin
					ch_q    <= heap_rdata;
					state_q <= S_DN_LNODE;
				end
				S_DN_LNODE: begin
					ch_dist_q <= node_rdata.distance;
					ch_pred_q <= node_rdata.pred;
					cr_q      <= heap_rdata;
					state_q   <= (j_q < hc_q) ? S_DN_RNODE : S_DN_CMP;
				end
				S_DN_RNODE: begin
					// right child only when the left one is strictly larger
					if (ch_dist_q > node_rdata.distance) begin
						ch_q      <= cr_q;
						ch_dist_q <= node_rdata.distance;
						ch_pred_q <= node_rdata.pred;
						j_q       <= imhd_pkg::pos_t'(j_q + 1'b1);
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (ch_dist_q < ld_q) begin
						i_q     <= j_q;
						state_q <= S_DN_LOOP;
					end else begin
						state_q <= S_DN_FIN;
					end
				end
				S_DN_FIN: state_q <= S_POP_CLR;
				S_POP_CLR: begin
					flag_q  <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						relax_taken_q <= (op_q == imhd_pkg::REQ_RELAX) && flag_q;
						pop_valid_q   <= (op_q == imhd_pkg::REQ_POP) && flag_q;
						popped_node_q <= ((op_q == imhd_pkg::REQ_POP) && flag_q) ?
							8'(top_q) : '0;
						popped_dist_q <= ((op_q == imhd_pkg::REQ_POP) && flag_q) ?
							32'(top_dist_q) : '0;
						popped_pred_q <= ((op_q == imhd_pkg::REQ_POP) && flag_q) ?
							8'(top_pred_q) : '0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/indexed_min_heap_decrease_key_top.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_top
// Indexed binary min-heap with decrease-key for a shortest-path engine.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A taken relax reads the node record,
// then climbs the node up the heap level by level, with a final write-back when
// it stops; a refused relax is answered without a heap walk. A pop reads the top
// and the last slot with their node records, then walks the last node down from
// the root level by level (reading the right child too when one is present) and
// ends with the compare that stops the walk; an empty pop skips the heap walk.
// Each of the two RAMs (node records and heap slots) has a single read port, so
// every level needs a slot read followed by a node read before the compare.
// The result sits in an output register, so the next transaction is taken while
// the previous result waits. Reached marks are flops cleared by reset; no
// clearing pass is needed.
module indexed_min_heap_decrease_key_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  node_id,
	input  logic [7:0]  pred_id,
	input  logic [31:0] offered_dist,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        relax_taken,
	output logic        pop_valid,
	output logic [7:0]  popped_node,
	output logic [31:0] popped_dist,
	output logic [7:0]  popped_pred
);

	imhd_pkg::node_req_t                  node_req;
	imhd_pkg::heap_req_t                  heap_req;
	logic [imhd_pkg::NODE_WORD_W-1:0]     node_rdata_raw;
	imhd_pkg::node_t                      heap_rdata;

	// sequencer
	imhd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.node_id      (node_id),
		.pred_id      (pred_id),
		.offered_dist (offered_dist),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.relax_taken  (relax_taken),
		.pop_valid    (pop_valid),
		.popped_node  (popped_node),
		.popped_dist  (popped_dist),
		.popped_pred  (popped_pred),
		.node_req     (node_req),
		.node_rdata   (imhd_pkg::node_word_t'(node_rdata_raw)),
		.heap_req     (heap_req),
		.heap_rdata   (heap_rdata)
	);

	// per-node records
	imhd_ram #(
		.WIDTH (imhd_pkg::NODE_WORD_W),
		.DEPTH (imhd_pkg::NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (node_req.we),
		.waddr (node_req.waddr),
		.wdata (node_req.wdata),
		.raddr (node_req.raddr),
		.rdata (node_rdata_raw)
	);

	// heap slots holding node ids
	imhd_ram #(
		.WIDTH (imhd_pkg::NODE_W),
		.DEPTH (imhd_pkg::HEAP_DEPTH)
	) u_heap_ram (
		.clk   (clk),
		.we    (heap_req.we),
		.waddr (heap_req.waddr),
		.wdata (heap_req.wdata),
		.raddr (heap_req.raddr),
		.rdata (heap_rdata)
	);

endmodule

// ===== rtl/imhd_checker.sv =====
// ----------------------------------------------------------------------------
// imhd_checker
// Port-level checks for the indexed min-heap, bound to the top level.
// ----------------------------------------------------------------------------
module imhd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        relax_taken,
	input logic        pop_valid,
	input logic [7:0]  popped_node,
	input logic [31:0] popped_dist,
	input logic [7:0]  popped_pred
);

	// a held result is not dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a result is either a relax outcome or a pop outcome
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(relax_taken && pop_valid))
		else $error("relax and pop flags both set");

	// no pop payload without a popped node
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pop_valid |-> popped_node == 8'd0 && popped_dist == 32'd0
			&& popped_pred == 8'd0)
		else $error("pop fields set without a popped node");

	// the block is busy in the cycle after it takes a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");

endmodule

bind indexed_min_heap_decrease_key_top imhd_checker u_imhd_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Indexed min-heap with decrease-key: self-checking testbench
// Drives relax and pop transactions through the valid/ready ports, predicts
// each answer with a behavioral heap model, and checks the results in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		bit        taken;
		bit        pvalid;
		bit [7:0]  pnode;
		bit [31:0] pdist;
		bit [7:0]  ppred;
	} answer_t;

	// Heap model plus queue of expected answers
	class heap_scoreboard;
		bit [31:0] node_dist[imhd_pkg::NODE_COUNT];
		bit [7:0]  pred[imhd_pkg::NODE_COUNT];
		bit        reached[imhd_pkg::NODE_COUNT];
		int        pos[imhd_pkg::NODE_COUNT];
		int        slots[imhd_pkg::NODE_COUNT+1];
		int        count;
		answer_t   pending[$];
		int        mismatches;

		function new();
			count = 0;
			mismatches = 0;
			foreach (reached[k]) begin
				reached[k] = 0;
				pos[k] = 0;
			end
		endfunction

		function void put(int s, int nd);
			slots[s] = nd;
			pos[nd] = s;
		endfunction

		function bit [31:0] sdist(int s);
			return node_dist[slots[s]];
		endfunction

		// Compute the answer to one accepted transaction
		function void note_request(bit rt, bit [7:0] nd, bit [7:0] pd, bit [31:0] d);
			answer_t a;
			int i, j, top, last;
			bit [31:0] ld;
			a = '{default: 0};
			if (rt == imhd_pkg::REQ_RELAX) begin
				if (!(reached[nd] && d >= node_dist[nd])) begin
					i = pos[nd];
					if (i == 0 || i > count) begin
						count++;
						i = count;
					end
					node_dist[nd] = d;
					pred[nd] = pd;
					reached[nd] = 1;
					while (i > 1) begin
						j = i / 2;
						if (!(d < sdist(j))) break;
						put(i, slots[j]);
						i = j;
					end
					put(i, nd);
					a.taken = 1;
				end
			end else if (count > 0) begin
				top = slots[1];
				last = slots[count];
				ld = node_dist[last];
				count--;
				i = 1;
				while (i < count && 2 * i <= count) begin
					j = 2 * i;
					if (j < count && sdist(j) > sdist(j + 1)) j++;
					if (sdist(j) >= ld) break;
					put(i, slots[j]);
					i = j;
				end
				put(i, last);
				pos[top] = 0;
				a.pvalid = 1;
				a.pnode = 8'(top);
				a.pdist = node_dist[top];
				a.ppred = pred[top];
			end
			pending.push_back(a);
		endfunction

		function void check_answer(answer_t got);
			answer_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at %0t", $realtime);
				return;
			end
			exp = pending.pop_front();
			if (got != exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: exp %0b %0b %0d %0d %0d got %0b %0b %0d %0d %0d",
						$realtime, exp.taken, exp.pvalid, exp.pnode, exp.pdist, exp.ppred,
						got.taken, got.pvalid, got.pnode, got.pdist, got.ppred);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic        req_type = 0;
	logic [7:0]  node_id = 0;
	logic [7:0]  pred_id = 0;
	logic [31:0] offered_dist = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic        relax_taken, pop_valid;
	logic [7:0]  popped_node, popped_pred;
	logic [31:0] popped_dist;

	heap_scoreboard sb = new();
	bit stall_long = 0;
	bit sending_done = 0;

	indexed_min_heap_decrease_key_top dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	// Offer one transaction and hold it until accepted
	task automatic send_req(bit rt, bit [7:0] nd, bit [7:0] pd, bit [31:0] d);
		int g;
		req_type <= rt;
		node_id <= nd;
		pred_id <= pd;
		offered_dist <= d;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		sb.note_request(rt, nd, pd, d);
		@(negedge clk);
		// no gap: valid stays up and the next call loads the next payload
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
	endtask

	// Random distance: mostly small values so ties and decrease-keys happen
	function automatic bit [31:0] rand_dist();
		case ($urandom_range(0, 9))
			0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			1: return $urandom;
			2: return $urandom_range(0, 3);
			default: return $urandom_range(0, 200);
		endcase
	endfunction

	// Result side: sample at rising edge, back-pressure at falling edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_answer('{relax_taken, pop_valid, popped_node, popped_dist, popped_pred});
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_long) begin
				out_ready <= 0;
			end else if ($urandom_range(0, 4) == 0) begin
				g = gap_len();
				if (g > 0) begin
					out_ready <= 0;
					repeat (g) @(negedge clk);
				end
				out_ready <= 1;
			end else begin
				out_ready <= 1;
			end
		end
	end

	initial begin
		int nn;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: empty pop, extremes, ties, decrease-key, re-reach after pop
		send_req(imhd_pkg::REQ_POP, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		send_req(imhd_pkg::REQ_RELAX, 8'd0, 8'd255, 32'hFFFF_FFFF);
		send_req(imhd_pkg::REQ_RELAX, 8'd255, 8'd0, 32'd0);
		send_req(imhd_pkg::REQ_RELAX, 8'd10, 8'd1, 32'd5);
		send_req(imhd_pkg::REQ_RELAX, 8'd11, 8'd2, 32'd5);
		send_req(imhd_pkg::REQ_RELAX, 8'd12, 8'd3, 32'd5);
		send_req(imhd_pkg::REQ_RELAX, 8'd10, 8'd4, 32'd5);
		send_req(imhd_pkg::REQ_RELAX, 8'd10, 8'd4, 32'd6);
		send_req(imhd_pkg::REQ_RELAX, 8'd0, 8'd7, 32'd1);
		send_req(imhd_pkg::REQ_RELAX, 8'd12, 8'hAA, 32'd4);
		for (int k = 0; k < 6; k++)
			send_req(imhd_pkg::REQ_POP, 8'h55, 8'hAA, 32'h5555_5555);
		send_req(imhd_pkg::REQ_RELAX, 8'd0, 8'd9, 32'd0);
		send_req(imhd_pkg::REQ_RELAX, 8'd255, 8'd9, 32'd0);
		send_req(imhd_pkg::REQ_POP, 8'd0, 8'd0, 32'd0);
		send_req(imhd_pkg::REQ_POP, 8'd0, 8'd0, 32'd0);

		// Hold results back while requests keep coming
		stall_long = 1;
		fork
			begin
				repeat (300) @(negedge clk);
				stall_long = 0;
			end
			for (int k = 0; k < 20; k++)
				send_req(imhd_pkg::REQ_RELAX, 8'($urandom), 8'($urandom), rand_dist());
		join

		// Random: fill phases build a deep heap, drain phases empty it
		for (int ph = 0; ph < 8; ph++) begin
			nn = (ph % 3 == 0) ? 255 : $urandom_range(4, 60);
			for (int k = 0; k < 160; k++) begin
				if ($urandom_range(0, 99) < 12)
					send_req(imhd_pkg::REQ_POP, 8'($urandom), 8'($urandom), $urandom);
				else
					send_req(imhd_pkg::REQ_RELAX, 8'($urandom_range(0, nn)), 8'($urandom),
						rand_dist());
			end
			repeat (sb.count + 2 + $urandom_range(0, 5))
				send_req(imhd_pkg::REQ_POP, 8'($urandom), 8'($urandom), $urandom);
		end

		in_valid <= 0;
		sending_done = 1;
	end

	// Final wait and verdict
	initial begin
		wait (sending_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
